// ===== design/ipv4dp_pkg.sv =====
// shared types and constants for the ipv4 dotted address parser
package ipv4dp_pkg;

    localparam int MAX_PARTS = 4;
    localparam int CHAR_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int PART_W    = 9;
    localparam int COUNT_W   = 2;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_ZERO  = 4'b0010,
        PH_NUM   = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

endpackage

// ===== design/ipv4_dotted_address_parser.sv =====
// ipv4 dotted address parser: one character per beat, one verdict per string
// an accepted input beat goes through the input register, then the result register, to m_tvalid
// throughput: one character per cycle while m_tready keeps the result register free, set by the
//   combinational parse update between the input register and the result register
// reset: rst_n is asynchronous, active low; it clears the parse state to
//   expect part start and empties the input and result registers
module ipv4_dotted_address_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] first_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic        m_tuser    // [0] valid_res
);

    localparam int NSTORE = ipv4dp_pkg::MAX_PARTS - 1;

    // input register
    logic                              in_valid_reg;
    logic [ipv4dp_pkg::CHAR_W-1:0]     char_reg;
    logic                              first_reg;

    // parse state
    ipv4dp_pkg::phase_t                phase_reg, phase_next;
    ipv4dp_pkg::radix_t                radix_reg, radix_next;
    logic [ipv4dp_pkg::ADDR_W-1:0]     acc_reg, acc_next;
    logic [ipv4dp_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [ipv4dp_pkg::PART_W-1:0]     parts_reg [NSTORE];

    // result register
    logic                              out_valid_reg;
    logic                              res_ok_reg;
    logic [ipv4dp_pkg::ADDR_W-1:0]     res_addr_reg;

    // handshake: the stage moves when the result register can take a beat
    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_ok_reg;
    assign m_tdata  = res_addr_reg;

    // current state, with a first character starting from the clean state
    ipv4dp_pkg::phase_t             cur_phase;
    ipv4dp_pkg::radix_t             cur_radix;
    logic [ipv4dp_pkg::ADDR_W-1:0]  cur_acc;
    logic [ipv4dp_pkg::COUNT_W-1:0] cur_count;

    assign cur_phase = first_reg ? ipv4dp_pkg::PH_START : phase_reg;
    assign cur_radix = first_reg ? ipv4dp_pkg::RX_DEC   : radix_reg;
    assign cur_acc   = first_reg ? '0 : acc_reg;
    assign cur_count = first_reg ? '0 : count_reg;

    // character classes
    logic       is_dec;
    logic       is_hexl;
    logic       is_ws;
    logic [3:0] hex_v;

    always_comb
    begin
        is_dec  = (char_reg >= ipv4dp_pkg::CH_0) && (char_reg <= ipv4dp_pkg::CH_9);
        is_hexl = 1'b0;
        hex_v   = char_reg[3:0];
        if ((char_reg >= ipv4dp_pkg::CH_LA) && (char_reg <= ipv4dp_pkg::CH_LF))
        begin
            is_hexl = 1'b1;
            hex_v   = 4'(char_reg - ipv4dp_pkg::CH_LA + 8'd10);
        end
        else if ((char_reg >= ipv4dp_pkg::CH_UA) && (char_reg <= ipv4dp_pkg::CH_UF))
        begin
            is_hexl = 1'b1;
            hex_v   = 4'(char_reg - ipv4dp_pkg::CH_UA + 8'd10);
        end
        is_ws = (char_reg == ipv4dp_pkg::CH_SPACE) ||
                ((char_reg >= ipv4dp_pkg::CH_TAB) && (char_reg <= ipv4dp_pkg::CH_CR));
    end

    // accumulator times the running base, done with shifts and, for decimal, one add
    logic [ipv4dp_pkg::ADDR_W-1:0] acc_scaled;

    always_comb
    begin
        case (cur_radix)
            ipv4dp_pkg::RX_HEX: acc_scaled = cur_acc << 4;
            ipv4dp_pkg::RX_OCT: acc_scaled = cur_acc << 3;
            default:            acc_scaled = (cur_acc << 3) + (cur_acc << 1);
        endcase
    end

    // final width checks for the forms a, a.b, a.b.c and a.b.c.d
    logic                          fin_ok;
    logic [ipv4dp_pkg::ADDR_W-1:0] fin_val;

    always_comb
    begin
        case (cur_count)
            2'd0:
            begin
                fin_ok  = 1'b1;
                fin_val = cur_acc;
            end
            2'd1:
            begin
                fin_ok  = (cur_acc[31:24] == '0) && !parts_reg[0][8];
                fin_val = {parts_reg[0][7:0], cur_acc[23:0]};
            end
            2'd2:
            begin
                fin_ok  = (cur_acc[31:16] == '0) && !parts_reg[0][8] && !parts_reg[1][8];
                fin_val = {parts_reg[0][7:0], parts_reg[1][7:0], cur_acc[15:0]};
            end
            default:
            begin
                fin_ok  = (cur_acc[31:8] == '0) && !parts_reg[0][8] &&
                          !parts_reg[1][8] && !parts_reg[2][8];
                fin_val = {parts_reg[0][7:0], parts_reg[1][7:0],
                           parts_reg[2][7:0], cur_acc[7:0]};
            end
        endcase
    end

    // parse step
    logic                          emit;
    logic                          emit_ok;
    logic                          store_part;
    logic                          num_path;

    always_comb
    begin
        phase_next = cur_phase;
        radix_next = cur_radix;
        acc_next   = cur_acc;
        count_next = cur_count;
        emit       = 1'b0;
        emit_ok    = 1'b0;
        store_part = 1'b0;
        num_path   = 1'b0;

        case (cur_phase)
            ipv4dp_pkg::PH_START:
            begin
                if (!is_dec)
                begin
                    emit = 1'b1;
                end
                else if (char_reg == ipv4dp_pkg::CH_0)
                begin
                    acc_next   = '0;
                    radix_next = ipv4dp_pkg::RX_OCT;
                    phase_next = ipv4dp_pkg::PH_ZERO;
                end
                else
                begin
                    acc_next   = {28'd0, char_reg[3:0]};
                    radix_next = ipv4dp_pkg::RX_DEC;
                    phase_next = ipv4dp_pkg::PH_NUM;
                end
            end
            ipv4dp_pkg::PH_ZERO:
            begin
                if ((char_reg == ipv4dp_pkg::CH_LX) || (char_reg == ipv4dp_pkg::CH_UX))
                begin
                    radix_next = ipv4dp_pkg::RX_HEX;
                    phase_next = ipv4dp_pkg::PH_NUM;
                end
                else
                begin
                    num_path = 1'b1;
                end
            end
            ipv4dp_pkg::PH_NUM:
            begin
                num_path = 1'b1;
            end
            default:
            begin
                // done: characters are dropped until the next first character
            end
        endcase

        if (num_path)
        begin
            if (is_dec)
            begin
                acc_next   = acc_scaled + {28'd0, char_reg[3:0]};
                phase_next = ipv4dp_pkg::PH_NUM;
            end
            else if ((cur_radix == ipv4dp_pkg::RX_HEX) && is_hexl)
            begin
                acc_next   = {cur_acc[27:0], hex_v};
                phase_next = ipv4dp_pkg::PH_NUM;
            end
            else if (char_reg == ipv4dp_pkg::CH_DOT)
            begin
                if (cur_count >= ipv4dp_pkg::COUNT_W'(NSTORE))
                begin
                    emit = 1'b1;
                end
                else
                begin
                    store_part = 1'b1;
                    count_next = cur_count + 1'b1;
                    phase_next = ipv4dp_pkg::PH_START;
                end
            end
            else if ((char_reg == ipv4dp_pkg::CH_NUL) || is_ws)
            begin
                emit    = 1'b1;
                emit_ok = fin_ok;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            phase_next = ipv4dp_pkg::PH_DONE;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ipv4dp_pkg::PH_START;
            radix_reg     <= ipv4dp_pkg::RX_DEC;
            acc_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= fire && emit;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg  <= s_tdata;
            first_reg <= s_tuser;
        end
        if (fire && store_part)
        begin
            parts_reg[cur_count] <= {(cur_acc[31:8] != '0), cur_acc[7:0]};
        end
        if (fire && emit)
        begin
            res_ok_reg   <= emit_ok;
            // byte reverse into network order, zero on failure
            res_addr_reg <= emit_ok ? {fin_val[7:0], fin_val[15:8],
                                       fin_val[23:16], fin_val[31:24]} : '0;
        end
    end

endmodule
